[design/sv39ptw_pkg.sv]
// Shared types, codes and address helpers for the Sv39 page-table walker.
// No dependencies; imported by sv39ptw_walk and sv39_page_table_walker.
`timescale 1ns / 1ps
`default_nettype none

package sv39ptw_pkg;

   localparam int MEM_WORDS = 4096;
   localparam int ADDR_W    = $clog2(MEM_WORDS);

   localparam logic [2:0] CMD_WRITE_WORD = 3'd0;
   localparam logic [2:0] CMD_READ_WORD  = 3'd1;
   localparam logic [2:0] CMD_TRANSLATE  = 3'd2;
   localparam logic [2:0] CMD_MAP_PAGE   = 3'd3;
   localparam logic [2:0] CMD_UNMAP_PAGE = 3'd4;
   localparam logic [2:0] CMD_CLEAR_USER = 3'd5;

   localparam logic [2:0] ST_OK           = 3'd0;
   localparam logic [2:0] ST_RANGE        = 3'd1;
   localparam logic [2:0] ST_MISSING      = 3'd2;
   localparam logic [2:0] ST_LEAF_INVALID = 3'd3;
   localparam logic [2:0] ST_NOT_USER     = 3'd4;
   localparam logic [2:0] ST_ALREADY      = 3'd5;
   localparam logic [2:0] ST_MISALIGNED   = 3'd6;

   localparam int PTE_V = 0;
   localparam int PTE_U = 4;

   typedef struct packed {
      logic              en;
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [63:0]       wdata;
   } ram_req_type;

   // word index of entry idx in the table page ppn, wrapped to the memory
   function automatic logic [ADDR_W-1:0] table_addr(input logic [43:0] ppn,
                                                    input logic [8:0]  idx);
      logic [52:0] full;
      full = {ppn, idx};
      return full[ADDR_W-1:0];
   endfunction

   // word index of a physical byte address, wrapped to the memory
   function automatic logic [ADDR_W-1:0] word_addr(input logic [38:0] addr);
      return addr[ADDR_W+2:3];
   endfunction

endpackage

`default_nettype wire

[design/sv39ptw_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     en,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/sv39ptw_walk.sv]
// Command sequencer: decodes transactions, walks the three table levels,
// updates leaves and holds the result register. Depends on sv39ptw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sv39ptw_walk import sv39ptw_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [43:0] root_ppn,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [38:0] req_virt_addr,
   input  wire logic [55:0] req_phys_addr,
   input  wire logic [7:0]  req_perm_flags,
   input  wire logic [63:0] req_write_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_status,
   output      logic [63:0] rsp_read_data,
   output      ram_req_type ram_req,
   input  wire logic [63:0] ram_rdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_RDATA = 3'd1;
   localparam logic [2:0] S_LVL2  = 3'd2;
   localparam logic [2:0] S_LVL1  = 3'd3;
   localparam logic [2:0] S_LEAF  = 3'd4;
   localparam logic [2:0] S_HOLD  = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [38:0] va_ff, va_in;
   logic [43:0] pa_ff, pa_in;
   logic [7:0]  perm_ff, perm_in;
   logic [2:0]  pend_status_ff, pend_status_in;
   logic [63:0] pend_data_ff, pend_data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_status_ff, rsp_status_in;
   logic [63:0] rsp_data_ff, rsp_data_in;
   logic [ADDR_W-1:0] leaf_addr_ff, leaf_addr_in;

   logic        finish;
   logic [2:0]  fin_status;
   logic [63:0] fin_data;
   logic        rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      va_in          = va_ff;
      pa_in          = pa_ff;
      perm_in        = perm_ff;
      pend_status_in = pend_status_ff;
      pend_data_in   = pend_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_data_in    = rsp_data_ff;
      finish         = 1'b0;
      fin_status     = ST_OK;
      fin_data       = '0;
      ram_req.en     = 1'b0;
      ram_req.we     = 1'b0;
      ram_req.addr   = table_addr(root_ppn, va_ff[38:30]);
      ram_req.wdata  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               va_in   = req_virt_addr;
               pa_in   = req_phys_addr[55:12];
               perm_in = req_perm_flags;
               ram_req.addr = table_addr(root_ppn, req_virt_addr[38:30]);
               unique case (req_cmd)
                  CMD_WRITE_WORD, CMD_READ_WORD: begin
                     ram_req.addr = word_addr(req_virt_addr);
                     if (req_virt_addr[2:0] != 3'd0) begin
                        finish     = 1'b1;
                        fin_status = ST_MISALIGNED;
                     end else if (req_cmd == CMD_WRITE_WORD) begin
                        ram_req.en    = 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.wdata = req_write_data;
                        finish        = 1'b1;
                     end else begin
                        ram_req.en = 1'b1;
                        state_in   = S_RDATA;
                     end
                  end
                  CMD_TRANSLATE, CMD_CLEAR_USER: begin
                     if (req_virt_addr[38]) begin
                        finish     = 1'b1;
                        fin_status = ST_RANGE;
                     end else begin
                        ram_req.en = 1'b1;
                        state_in   = S_LVL2;
                     end
                  end
                  CMD_MAP_PAGE, CMD_UNMAP_PAGE: begin
                     if (req_virt_addr[11:0] != 12'd0 ||
                         (req_cmd == CMD_MAP_PAGE && req_phys_addr[11:0] != 12'd0)) begin
                        finish     = 1'b1;
                        fin_status = ST_MISALIGNED;
                     end else if (req_virt_addr[38]) begin
                        finish     = 1'b1;
                        fin_status = ST_RANGE;
                     end else begin
                        ram_req.en = 1'b1;
                        state_in   = S_LVL2;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_RDATA: begin
            finish   = 1'b1;
            fin_data = ram_rdata;
         end
         S_LVL2: begin
            ram_req.addr = table_addr(ram_rdata[53:10], va_ff[29:21]);
            if (!ram_rdata[PTE_V]) begin
               finish     = 1'b1;
               fin_status = ST_MISSING;
            end else begin
               ram_req.en = 1'b1;
               state_in   = S_LVL1;
            end
         end
         S_LVL1: begin
            ram_req.addr = table_addr(ram_rdata[53:10], va_ff[20:12]);
            if (!ram_rdata[PTE_V]) begin
               finish     = 1'b1;
               fin_status = ST_MISSING;
            end else begin
               ram_req.en = 1'b1;
               state_in   = S_LEAF;
            end
         end
         S_LEAF: begin
            // write back to the leaf fetched by the level-one step
            ram_req.addr = leaf_addr_ff;
            finish       = 1'b1;
            unique case (cmd_ff)
               CMD_TRANSLATE: begin
                  if (!ram_rdata[PTE_V]) begin
                     fin_status = ST_LEAF_INVALID;
                  end else if (!ram_rdata[PTE_U]) begin
                     fin_status = ST_NOT_USER;
                  end else begin
                     fin_data = {8'd0, ram_rdata[53:10], 12'd0};
                  end
               end
               CMD_MAP_PAGE: begin
                  if (ram_rdata[PTE_V]) begin
                     fin_status = ST_ALREADY;
                  end else begin
                     ram_req.en    = 1'b1;
                     ram_req.we    = 1'b1;
                     ram_req.wdata = {10'd0, pa_ff, 2'd0, perm_ff | 8'h01};
                  end
               end
               CMD_UNMAP_PAGE: begin
                  if (!ram_rdata[PTE_V]) begin
                     fin_status = ST_LEAF_INVALID;
                  end else begin
                     ram_req.en = 1'b1;
                     ram_req.we = 1'b1;
                  end
               end
               default: begin
                  ram_req.en    = 1'b1;
                  ram_req.we    = 1'b1;
                  ram_req.wdata = {ram_rdata[63:5], 1'b0, ram_rdata[3:0]};
               end
            endcase
         end
         S_HOLD: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_data_in   = pend_data_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         pend_status_in = fin_status;
         pend_data_in   = fin_data;
         if (rsp_free) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = fin_status;
            rsp_data_in   = fin_data;
            state_in      = S_IDLE;
         end else begin
            state_in = S_HOLD;
         end
      end
   end

   assign leaf_addr_in = (state_ff == S_LVL1) ? table_addr(ram_rdata[53:10], va_ff[20:12])
                                              : leaf_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      va_ff          <= va_in;
      pa_ff          <= pa_in;
      perm_ff        <= perm_in;
      pend_status_ff <= pend_status_in;
      pend_data_ff   <= pend_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_data_ff    <= rsp_data_in;
      leaf_addr_ff   <= leaf_addr_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule

`default_nettype wire

[design/sv39_page_table_walker.sv]
// Sv39 page-table walker: top level with the root register and table RAM.
// Depends on sv39ptw_pkg, sv39ptw_ram and sv39ptw_walk.
//
// Usage: each req_ transaction carries one command (write word, read word,
// translate, map page, unmap page, clear user) and yields exactly one rsp_
// transaction with a status code and a 64-bit data word. csr_we writes
// csr_wdata into the root page number; write it only while the block is idle.
// A word write, and any command rejected by its alignment or range check,
// is answered straight from the idle state; a word read passes through
// S_RDATA; a walk passes through S_LVL2, S_LVL1 and S_LEAF, ends early at a
// missing level and writes the leaf update in S_LEAF. Items are processed
// one at a time; a walk is paced by the chain of dependent reads on the
// single port of the table RAM, one per level.
// A result waits in the output register while req_ready stays high, so the
// next transaction is taken; if that one finishes while the earlier result
// is still not taken, the block holds it and drops req_ready until rsp_ready.
// Reset clears the root page number and the handshake state; the table
// memory is not cleared and must be written before it is read.
`timescale 1ns / 1ps
`default_nettype none

module sv39_page_table_walker import sv39ptw_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [43:0] csr_wdata,
   input  wire logic        req_valid,
   output      logic        req_ready,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [38:0] req_virt_addr,
   input  wire logic [55:0] req_phys_addr,
   input  wire logic [7:0]  req_perm_flags,
   input  wire logic [63:0] req_write_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_ready,
   output      logic [2:0]  rsp_status,
   output      logic [63:0] rsp_read_data
);

   logic [43:0] root_ppn_ff, root_ppn_in;
   ram_req_type ram_req;
   logic [63:0] ram_rdata;

   assign root_ppn_in = csr_we ? csr_wdata : root_ppn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ppn_ff <= '0;
      end else begin
         root_ppn_ff <= root_ppn_in;
      end
   end

   sv39ptw_walk u_walk (
      .clock          (clock),
      .reset          (reset),
      .root_ppn       (root_ppn_ff),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_virt_addr  (req_virt_addr),
      .req_phys_addr  (req_phys_addr),
      .req_perm_flags (req_perm_flags),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_read_data  (rsp_read_data),
      .ram_req        (ram_req),
      .ram_rdata      (ram_rdata)
   );

   sv39ptw_ram #(
      .WIDTH (64),
      .DEPTH (MEM_WORDS)
   ) u_ram (
      .clock (clock),
      .en    (ram_req.en),
      .we    (ram_req.we),
      .addr  (ram_req.addr),
      .wdata (ram_req.wdata),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire
